@@ src/spfc_pkg.sv @@
// shared types, codes and constants of the switch playback fade controller
package spfc_pkg;

	// field widths
	localparam int unsigned CMD_W    = 3;
	localparam int unsigned VOL_W    = 6;
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned STAT_W   = 2;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned HOLD_W   = 16;

	// player commands
	localparam logic [CMD_W-1:0] CMD_NONE         = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PLAY_ONESHOT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PLAY_LOOP    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SET_VOLUME   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_STOP         = 3'd4;

	// playback modes
	localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ONESHOT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LOOP    = 2'd2;

	// player status codes
	localparam logic [STAT_W-1:0] STATUS_STOPPED = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_PLAYING = 2'd1;

	// register map
	localparam int unsigned APB_ADDR_W = 5;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned REG_IDX_W  = 3;
	localparam logic [REG_IDX_W-1:0] REG_ON_HOLD        = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_OFF_HOLD       = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_FADE_DURATION  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_FULL_VOLUME    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ONESHOT_AVAIL  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_LOOP_AVAIL     = 3'd5;

	// register reset values
	localparam logic [HOLD_W-1:0] ON_HOLD_RST       = 16'd1000;
	localparam logic [HOLD_W-1:0] OFF_HOLD_RST      = 16'd50;
	localparam logic [HOLD_W-1:0] FADE_DURATION_RST = 16'd3000;
	localparam logic [VOL_W-1:0]  FULL_VOLUME_RST   = 6'd30;

	// poll queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// results of one poll
	localparam int unsigned PEND_DEPTH = 4;
	localparam int unsigned PEND_IDX_W = $clog2(PEND_DEPTH);
	localparam int unsigned PEND_CNT_W = $clog2(PEND_DEPTH + 1);

	// fade divider: quotient never exceeds full volume
	localparam int unsigned DIV_NUM_W   = HOLD_W + VOL_W;
	localparam int unsigned DIV_STEPS   = VOL_W;
	localparam int unsigned DIV_STEP_W  = $clog2(DIV_STEPS + 1);

	typedef struct packed {
		logic                switch_closed;
		logic [STAT_W-1:0]   player_status;
		logic [TIME_W-1:0]   now_ms;
	} poll_t;

	// classified poll as held in the queue
	typedef struct packed {
		logic   stop_edge;
		poll_t  poll;
	} entry_t;

	typedef struct packed {
		logic    valid;
		entry_t  entry;
	} head_t;

	typedef struct packed {
		logic [HOLD_W-1:0] close_hold;
		logic [HOLD_W-1:0] open_hold;
		logic [HOLD_W-1:0] fade_len;
		logic [VOL_W-1:0]  full_volume;
		logic              oneshot_available;
		logic              loop_available;
	} cfg_t;

endpackage

@@ src/spfc_if.sv @@
// poll and result channel interfaces
interface spfc_poll_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 switch_closed;
	logic [spfc_pkg::STAT_W-1:0]          player_status;
	logic [spfc_pkg::TIME_W-1:0]          now_ms;

	modport source (output valid, output switch_closed, output player_status, output now_ms,
		input ready);
	modport sink (input valid, input switch_closed, input player_status, input now_ms,
		output ready);
endinterface

interface spfc_result_if;
	logic                                 valid;
	logic                                 ready;
	logic [spfc_pkg::CMD_W-1:0]           command;
	logic [spfc_pkg::VOL_W-1:0]           volume;
	logic [spfc_pkg::MODE_W-1:0]          mode;
	logic                                 last;

	modport source (output valid, output command, output volume, output mode, output last,
		input ready);
	modport sink (input valid, input command, input volume, input mode, input last,
		output ready);
endinterface

@@ src/spfc_front.sv @@
// front end: accepts polls, flags stop edges and queues them for the back end
module spfc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	spfc_poll_if.sink             poll,
	output spfc_pkg::head_t       head,
	input  logic                  pop
);

	spfc_pkg::entry_t                   queue_q [spfc_pkg::QUEUE_DEPTH];
	logic [spfc_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [spfc_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [spfc_pkg::QCNT_W-1:0]        count_q;
	logic [spfc_pkg::STAT_W-1:0]        prev_status_q;
	logic                               push;
	logic                               take;
	spfc_pkg::entry_t                   new_entry;

	// queue not full
	assign poll.ready = (count_q != spfc_pkg::QCNT_W'(spfc_pkg::QUEUE_DEPTH));
	assign push       = poll.valid && poll.ready;
	assign take       = pop && (count_q != '0);

	// classify: playing-to-stopped edge against the previous poll
	always_comb begin
		new_entry.poll.switch_closed = poll.switch_closed;
		new_entry.poll.player_status = poll.player_status;
		new_entry.poll.now_ms        = poll.now_ms;
		new_entry.stop_edge = (prev_status_q == spfc_pkg::STATUS_PLAYING) &&
			(poll.player_status == spfc_pkg::STATUS_STOPPED);
	end

	assign head.valid = (count_q != '0);
	assign head.entry = queue_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_entry;
		end
	end

	// pointers, fill count and previous status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q      <= '0;
			rd_ptr_q      <= '0;
			count_q       <= '0;
			prev_status_q <= spfc_pkg::STATUS_STOPPED;
		end else begin
			if (push) begin
				wr_ptr_q      <= wr_ptr_q + spfc_pkg::QPTR_W'(1);
				prev_status_q <= poll.player_status;
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + spfc_pkg::QPTR_W'(1);
			end
			if (push && !take) begin
				count_q <= count_q + spfc_pkg::QCNT_W'(1);
			end else if (take && !push) begin
				count_q <= count_q - spfc_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

@@ src/spfc_div.sv @@
// restoring divider for the fade volume, one quotient bit per cycle
module spfc_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [spfc_pkg::DIV_NUM_W-1:0]    num,
	input  logic [spfc_pkg::HOLD_W-1:0]       den,
	output logic                              done,
	output logic [spfc_pkg::VOL_W-1:0]        quo
);

	logic [spfc_pkg::HOLD_W-1:0]      rem_q;
	logic [spfc_pkg::HOLD_W-1:0]      den_q;
	logic [spfc_pkg::VOL_W-1:0]       shift_q;
	logic [spfc_pkg::DIV_STEP_W-1:0]  step_q;
	logic                             busy_q;
	logic                             done_q;
	logic [spfc_pkg::HOLD_W:0]        trial;
	logic [spfc_pkg::HOLD_W:0]        diff;
	logic                             fits;

	// partial remainder with the next numerator bit brought down
	assign trial = {rem_q, shift_q[spfc_pkg::VOL_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = (trial >= {1'b0, den_q});

	assign done = done_q;
	assign quo  = shift_q;

	// datapath: quotient bits shift in where numerator bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= num[spfc_pkg::DIV_NUM_W-1:spfc_pkg::VOL_W];
			shift_q <= num[spfc_pkg::VOL_W-1:0];
			den_q   <= den;
		end else if (busy_q) begin
			rem_q   <= fits ? diff[spfc_pkg::HOLD_W-1:0] : trial[spfc_pkg::HOLD_W-1:0];
			shift_q <= {shift_q[spfc_pkg::VOL_W-2:0], fits};
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= spfc_pkg::DIV_STEP_W'(spfc_pkg::DIV_STEPS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				step_q <= step_q - spfc_pkg::DIV_STEP_W'(1);
				if (step_q == spfc_pkg::DIV_STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ src/spfc_back.sv @@
// back end: edge, fade and debounce sequencer with result buffer and output register
module spfc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  spfc_pkg::cfg_t        cfg,
	input  spfc_pkg::head_t       head,
	output logic                  pop,
	spfc_result_if.source         result
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EDGE = 3'd1;
	localparam logic [2:0] ST_FADE = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DEB  = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;

	logic [2:0]                           state_q;
	logic                                 sw_q;
	logic                                 edge_q;
	logic [spfc_pkg::TIME_W-1:0]          now_q;
	logic [spfc_pkg::MODE_W-1:0]          mode_q;
	logic                                 accepted_q;
	logic [spfc_pkg::TIME_W-1:0]          hold_start_q;
	logic                                 fade_active_q;
	logic [spfc_pkg::TIME_W-1:0]          fade_start_q;
	logic                                 fade_done_q;
	logic [spfc_pkg::HOLD_W-1:0]          elapsed_q;
	logic [spfc_pkg::CMD_W-1:0]           pend_cmd_q [spfc_pkg::PEND_DEPTH];
	logic [spfc_pkg::VOL_W-1:0]           pend_vol_q [spfc_pkg::PEND_DEPTH];
	logic [spfc_pkg::PEND_CNT_W-1:0]      count_q;
	logic [spfc_pkg::PEND_IDX_W-1:0]      emit_idx_q;
	logic                                 out_valid_q;
	logic [spfc_pkg::CMD_W-1:0]           out_cmd_q;
	logic [spfc_pkg::VOL_W-1:0]           out_vol_q;
	logic [spfc_pkg::MODE_W-1:0]          out_mode_q;
	logic                                 out_last_q;

	logic [spfc_pkg::TIME_W-1:0]          elapsed;
	logic [spfc_pkg::TIME_W-1:0]          hold_base;
	logic [spfc_pkg::TIME_W-1:0]          held_for;
	logic [spfc_pkg::HOLD_W-1:0]          need;
	logic                                 held;
	logic [spfc_pkg::HOLD_W-1:0]          fade_left;
	logic [spfc_pkg::DIV_NUM_W-1:0]       div_num;
	logic                                 div_start;
	logic                                 div_done;
	logic [spfc_pkg::VOL_W-1:0]           div_quo;
	logic                                 load;
	logic                                 is_last;
	logic [spfc_pkg::PEND_IDX_W-1:0]      wr_idx;

	// fade timing
	assign elapsed   = now_q - fade_start_q;
	assign fade_left = cfg.fade_len - elapsed_q;
	assign div_num   = spfc_pkg::DIV_NUM_W'(cfg.full_volume) * spfc_pkg::DIV_NUM_W'(fade_left);
	assign div_start = (state_q == ST_FADE) && fade_active_q && !fade_done_q;

	// debounce timing; a zero start stamp means unarmed
	assign hold_base = (hold_start_q == '0) ? now_q : hold_start_q;
	assign held_for  = now_q - hold_base;
	assign need      = sw_q ? cfg.close_hold : cfg.open_hold;
	assign held      = (held_for >= {{(spfc_pkg::TIME_W - spfc_pkg::HOLD_W){1'b0}}, need});

	assign wr_idx = count_q[spfc_pkg::PEND_IDX_W-1:0];

	// output register loads while empty or while its beat is taken
	assign load    = (state_q == ST_EMIT) && (!out_valid_q || result.ready);
	assign is_last = ((spfc_pkg::PEND_CNT_W'(emit_idx_q) + spfc_pkg::PEND_CNT_W'(1)) == count_q);
	assign pop     = (state_q == ST_IDLE) && head.valid;

	assign result.valid   = out_valid_q;
	assign result.command = out_cmd_q;
	assign result.volume  = out_vol_q;
	assign result.mode    = out_mode_q;
	assign result.last    = out_last_q;

	spfc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (cfg.fade_len),
		.done   (div_done),
		.quo    (div_quo)
	);

	// poll fields and pending result buffer
	always_ff @(posedge clk) begin
		if (pop) begin
			sw_q   <= head.entry.poll.switch_closed;
			now_q  <= head.entry.poll.now_ms;
			edge_q <= head.entry.stop_edge;
		end
		if (state_q == ST_EDGE) begin
			fade_done_q <= (elapsed >= {{(spfc_pkg::TIME_W - spfc_pkg::HOLD_W){1'b0}},
				cfg.fade_len});
			elapsed_q   <= elapsed[spfc_pkg::HOLD_W-1:0];
		end
		case (state_q)
			ST_EDGE: begin
				if (edge_q && !fade_active_q && (mode_q == spfc_pkg::MODE_ONESHOT) &&
						sw_q && cfg.loop_available) begin
					pend_cmd_q[0] <= spfc_pkg::CMD_PLAY_LOOP;
					pend_vol_q[0] <= '0;
				end
			end
			ST_FADE: begin
				// fade end: silence, stop, restore
				if (fade_active_q && fade_done_q) begin
					pend_cmd_q[0] <= spfc_pkg::CMD_SET_VOLUME;
					pend_vol_q[0] <= '0;
					pend_cmd_q[1] <= spfc_pkg::CMD_STOP;
					pend_vol_q[1] <= '0;
					pend_cmd_q[2] <= spfc_pkg::CMD_SET_VOLUME;
					pend_vol_q[2] <= cfg.full_volume;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					pend_cmd_q[wr_idx] <= spfc_pkg::CMD_SET_VOLUME;
					pend_vol_q[wr_idx] <= div_quo;
				end
			end
			ST_DEB: begin
				if ((sw_q != accepted_q) && held && sw_q && (mode_q == spfc_pkg::MODE_IDLE) &&
						cfg.oneshot_available) begin
					pend_cmd_q[wr_idx] <= spfc_pkg::CMD_PLAY_ONESHOT;
					pend_vol_q[wr_idx] <= '0;
				end else if (count_q == '0) begin
					pend_cmd_q[0] <= spfc_pkg::CMD_NONE;
					pend_vol_q[0] <= '0;
				end
			end
			default: begin
			end
		endcase
		if (load) begin
			out_cmd_q  <= pend_cmd_q[emit_idx_q];
			out_vol_q  <= pend_vol_q[emit_idx_q];
			out_mode_q <= mode_q;
			out_last_q <= is_last;
		end
	end

	// sequencer and playback state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			mode_q        <= spfc_pkg::MODE_IDLE;
			accepted_q    <= 1'b0;
			hold_start_q  <= '0;
			fade_active_q <= 1'b0;
			fade_start_q  <= '0;
			count_q       <= '0;
			emit_idx_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						count_q <= '0;
						state_q <= ST_EDGE;
					end
				end
				// stop edge ends a one-shot track
				ST_EDGE: begin
					if (edge_q && !fade_active_q && (mode_q == spfc_pkg::MODE_ONESHOT)) begin
						if (sw_q) begin
							mode_q <= spfc_pkg::MODE_LOOP;
							if (cfg.loop_available) begin
								count_q <= spfc_pkg::PEND_CNT_W'(1);
							end
						end else begin
							mode_q <= spfc_pkg::MODE_IDLE;
						end
					end
					state_q <= ST_FADE;
				end
				ST_FADE: begin
					if (!fade_active_q) begin
						state_q <= ST_DEB;
					end else if (fade_done_q) begin
						count_q       <= spfc_pkg::PEND_CNT_W'(3);
						fade_active_q <= 1'b0;
						mode_q        <= spfc_pkg::MODE_IDLE;
						state_q       <= ST_DEB;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						count_q <= count_q + spfc_pkg::PEND_CNT_W'(1);
						state_q <= ST_DEB;
					end
				end
				// debounce; an accepted change starts a track or a fade
				ST_DEB: begin
					if (sw_q != accepted_q) begin
						if (held) begin
							accepted_q   <= sw_q;
							hold_start_q <= '0;
							if (sw_q && (mode_q == spfc_pkg::MODE_IDLE)) begin
								if (cfg.oneshot_available) begin
									mode_q <= spfc_pkg::MODE_ONESHOT;
								end
							end else if (!sw_q && (mode_q inside
									{spfc_pkg::MODE_ONESHOT, spfc_pkg::MODE_LOOP})) begin
								if (!fade_active_q) begin
									fade_active_q <= 1'b1;
									fade_start_q  <= now_q;
								end
							end
						end else begin
							hold_start_q <= hold_base;
						end
					end else begin
						hold_start_q <= '0;
					end
					if ((sw_q != accepted_q) && held && sw_q && (mode_q == spfc_pkg::MODE_IDLE) &&
							cfg.oneshot_available) begin
						count_q <= count_q + spfc_pkg::PEND_CNT_W'(1);
					end else if (count_q == '0) begin
						count_q <= spfc_pkg::PEND_CNT_W'(1);
					end
					emit_idx_q <= '0;
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load) begin
						out_valid_q <= 1'b1;
						emit_idx_q  <= emit_idx_q + spfc_pkg::PEND_IDX_W'(1);
						if (is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ src/switch_playback_fade_controller_core.sv @@
// top level: register port, poll front end and command back end
//
//  channel  | dir | beat                                   | handshake
//  ---------+-----+----------------------------------------+-------------------------
//  poll     | in  | switch_closed, player_status, now_ms   | valid/ready
//  result   | out | command, volume, mode, last            | valid/ready
//  apb      | in  | six registers at byte address 4*index  | psel/penable, pready = 1
//
// a poll passes the sequencer states idle, edge, fade and debounce, then emit once
// per result beat; a fade step that computes a volume adds the divider state with
// the one-bit-per-cycle divider. a two-entry poll queue decouples the input from
// the sequencer, and the output register lets the next poll start while the final
// beat waits. reset clears control state (not data registers) and restores defaults.
module switch_playback_fade_controller_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [spfc_pkg::APB_ADDR_W-1:0]       paddr,
	input  logic [spfc_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [spfc_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                  pready,
	spfc_poll_if.sink                             poll,
	spfc_result_if.source                         result
);

	spfc_pkg::cfg_t                     cfg_q;
	spfc_pkg::head_t                    head;
	logic                               pop;
	logic                               wr_en;
	logic [spfc_pkg::REG_IDX_W-1:0]     reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[spfc_pkg::APB_ADDR_W-1:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.close_hold        <= spfc_pkg::ON_HOLD_RST;
			cfg_q.open_hold         <= spfc_pkg::OFF_HOLD_RST;
			cfg_q.fade_len          <= spfc_pkg::FADE_DURATION_RST;
			cfg_q.full_volume       <= spfc_pkg::FULL_VOLUME_RST;
			cfg_q.oneshot_available <= 1'b1;
			cfg_q.loop_available    <= 1'b1;
		end else if (wr_en) begin
			case (reg_idx)
				spfc_pkg::REG_ON_HOLD:       cfg_q.close_hold <= pwdata[spfc_pkg::HOLD_W-1:0];
				spfc_pkg::REG_OFF_HOLD:      cfg_q.open_hold <= pwdata[spfc_pkg::HOLD_W-1:0];
				spfc_pkg::REG_FADE_DURATION: begin
					cfg_q.fade_len <= pwdata[spfc_pkg::HOLD_W-1:0];
				end
				spfc_pkg::REG_FULL_VOLUME:   cfg_q.full_volume <= pwdata[spfc_pkg::VOL_W-1:0];
				spfc_pkg::REG_ONESHOT_AVAIL: cfg_q.oneshot_available <= pwdata[0];
				spfc_pkg::REG_LOOP_AVAIL:    cfg_q.loop_available <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// register reads
	always_comb begin
		case (reg_idx)
			spfc_pkg::REG_ON_HOLD:       prdata = spfc_pkg::APB_DATA_W'(cfg_q.close_hold);
			spfc_pkg::REG_OFF_HOLD:      prdata = spfc_pkg::APB_DATA_W'(cfg_q.open_hold);
			spfc_pkg::REG_FADE_DURATION: prdata = spfc_pkg::APB_DATA_W'(cfg_q.fade_len);
			spfc_pkg::REG_FULL_VOLUME:   prdata = spfc_pkg::APB_DATA_W'(cfg_q.full_volume);
			spfc_pkg::REG_ONESHOT_AVAIL: prdata = spfc_pkg::APB_DATA_W'(cfg_q.oneshot_available);
			spfc_pkg::REG_LOOP_AVAIL:    prdata = spfc_pkg::APB_DATA_W'(cfg_q.loop_available);
			default:                     prdata = '0;
		endcase
	end

	spfc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.poll   (poll),
		.head   (head),
		.pop    (pop)
	);

	spfc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule

@@ src/spfc_checker.sv @@
// result port checks and their binding to the top level
module spfc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            res_valid,
	input logic                            res_ready,
	input logic [spfc_pkg::CMD_W-1:0]      res_command,
	input logic [spfc_pkg::VOL_W-1:0]      res_volume,
	input logic [spfc_pkg::MODE_W-1:0]     res_mode,
	input logic                            res_last
);

	// a stalled beat stays and holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_command) &&
		$stable(res_volume) && $stable(res_mode) && $stable(res_last))
		else $error("stalled result beat changed");

	// a quiet poll gives a single beat with no volume
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_command == spfc_pkg::CMD_NONE) |-> res_last && (res_volume == '0))
		else $error("none command not alone");

	// stop sits inside the fade end sequence and carries no volume
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_command == spfc_pkg::CMD_STOP) |->
		!res_last && (res_volume == '0))
		else $error("stop beat malformed");

	// a one-shot start always reports one-shot mode
	a_oneshot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_command == spfc_pkg::CMD_PLAY_ONESHOT) |->
		(res_mode == spfc_pkg::MODE_ONESHOT) && res_last)
		else $error("one-shot start with wrong mode");

endmodule

bind switch_playback_fade_controller_core spfc_checker u_spfc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_command (result.command),
	.res_volume  (result.volume),
	.res_mode    (result.mode),
	.res_last    (result.last)
);
